// ----- hw/rtl/fpc_pkg.sv -----
package fpc_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int ADC_W         = 16;
    localparam int PRES_W        = 16;
    localparam int DIFF_W        = ADC_W + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int MAG_W         = 2 * ADC_W + FRACTION_BITS;
    localparam int VAL_W         = MAG_W + 2;
    localparam int OUT_W         = 32;
    localparam int SEG_W         = 2;
    localparam int CAL_POINTS    = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int PIPE_LATENCY  = MAG_W + 6;

    localparam logic [SEG_W-1:0] SEG_1 = SEG_W'(1);
    localparam logic [SEG_W-1:0] SEG_2 = SEG_W'(2);
    localparam logic [SEG_W-1:0] SEG_3 = SEG_W'(3);

    localparam logic [ADC_W-1:0] CAL_ADC_RST [CAL_POINTS] =
        '{16'd0, 16'd21845, 16'd43690, 16'd65535};
    localparam logic [PRES_W-1:0] CAL_PRES_RST [CAL_POINTS] =
        '{16'd0, 16'd21845, 16'd43690, 16'd65535};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_ADC_0  = 3'd0,
        REG_CAL_ADC_1  = 3'd1,
        REG_CAL_ADC_2  = 3'd2,
        REG_CAL_ADC_3  = 3'd3,
        REG_CAL_PRES_0 = 3'd4,
        REG_CAL_PRES_1 = 3'd5,
        REG_CAL_PRES_2 = 3'd6,
        REG_CAL_PRES_3 = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SEG_W-1:0]         seg;
        logic                     zero;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dp;
        logic signed [DIFF_W-1:0] span;
        logic [PRES_W-1:0]        p0;
    } job_t;

endpackage

// ----- hw/rtl/four_point_pressure_calibration.sv -----
// channel   | direction | transfer                      | payload
// ----------+-----------+-------------------------------+------------------------------------
// sample    | in        | start && !busy at clk rise    | adc_sample
// result    | out       | done, one cycle, no stall     | pressure_q8, segment_used,
//           |           |                               | saturated, zero_span
// config    | in        | cfg_write at clk rise         | cfg_index, cfg_data
//
// One sample per cycle. A result passes the front register, the queue, product stage A,
// the pipelined divider (one quotient bit per stage), the final-sum and the output registers.
// rst_n clears all valid flags and loads the default calibration table.
// The result side cannot stall, so the queue never fills and busy stays low.
module four_point_pressure_calibration (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fpc_pkg::ADC_W-1:0]         adc_sample,
    input  logic                              cfg_write,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output logic signed [fpc_pkg::OUT_W-1:0]  pressure_q8,
    output logic [fpc_pkg::SEG_W-1:0]         segment_used,
    output logic                              saturated,
    output logic                              zero_span
);
    import fpc_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    job_t pop_job;

    fpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .adc_sample (adc_sample),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_ready (push_ready),
        .busy       (busy),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    fpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job)
    );

    fpc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_job      (pop_job),
        .done         (done),
        .pressure_q8  (pressure_q8),
        .segment_used (segment_used),
        .saturated    (saturated),
        .zero_span    (zero_span)
    );

endmodule

// ----- hw/rtl/fpc_front.sv -----
module fpc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fpc_pkg::ADC_W-1:0]      adc_sample,
    input  logic                           cfg_write,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push_ready,
    output logic                           busy,
    output logic                           push_valid,
    output fpc_pkg::job_t                  push_job
);
    import fpc_pkg::*;

    logic [ADC_W-1:0]  cal_adc_reg  [CAL_POINTS];
    logic [PRES_W-1:0] cal_pres_reg [CAL_POINTS];
    logic              front_valid_reg;
    logic              front_valid_next;
    job_t              front_job_reg;
    job_t              job_next;
    logic [SEG_W-1:0]  seg;
    logic [ADC_W-1:0]  a0;
    logic [ADC_W-1:0]  a1;
    logic [PRES_W-1:0] p0;
    logic [PRES_W-1:0] p1;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAL_POINTS; i++)
            begin
                cal_adc_reg[i]  <= CAL_ADC_RST[i];
                cal_pres_reg[i] <= CAL_PRES_RST[i];
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAL_ADC_0:  cal_adc_reg[0]  <= cfg_data;
                REG_CAL_ADC_1:  cal_adc_reg[1]  <= cfg_data;
                REG_CAL_ADC_2:  cal_adc_reg[2]  <= cfg_data;
                REG_CAL_ADC_3:  cal_adc_reg[3]  <= cfg_data;
                REG_CAL_PRES_0: cal_pres_reg[0] <= cfg_data;
                REG_CAL_PRES_1: cal_pres_reg[1] <= cfg_data;
                REG_CAL_PRES_2: cal_pres_reg[2] <= cfg_data;
                REG_CAL_PRES_3: cal_pres_reg[3] <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        priority if (cal_adc_reg[1] > adc_sample)
            seg = SEG_1;
        else if (cal_adc_reg[2] > adc_sample)
            seg = SEG_2;
        else
            seg = SEG_3;
    end

    always_comb
    begin
        unique case (seg)
            SEG_1:
            begin
                a0 = cal_adc_reg[0];
                a1 = cal_adc_reg[1];
                p0 = cal_pres_reg[0];
                p1 = cal_pres_reg[1];
            end
            SEG_2:
            begin
                a0 = cal_adc_reg[1];
                a1 = cal_adc_reg[2];
                p0 = cal_pres_reg[1];
                p1 = cal_pres_reg[2];
            end
            default:
            begin
                a0 = cal_adc_reg[2];
                a1 = cal_adc_reg[3];
                p0 = cal_pres_reg[2];
                p1 = cal_pres_reg[3];
            end
        endcase
    end

    always_comb
    begin
        job_next.seg  = seg;
        job_next.zero = (a0 == a1);
        job_next.dx   = $signed({1'b0, adc_sample}) - $signed({1'b0, a0});
        job_next.dp   = $signed({1'b0, p1}) - $signed({1'b0, p0});
        job_next.span = $signed({1'b0, a1}) - $signed({1'b0, a0});
        job_next.p0   = p0;
    end

    assign busy   = front_valid_reg && !push_ready;
    assign accept = start && !busy;

    always_comb
    begin
        priority if (accept)
            front_valid_next = 1'b1;
        else if (push_ready)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            front_job_reg <= job_next;
    end

    assign push_valid = front_valid_reg;
    assign push_job   = front_job_reg;

endmodule

// ----- hw/rtl/fpc_queue.sv -----
module fpc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  fpc_pkg::job_t push_job,
    output logic          push_ready,
    output logic          pop_valid,
    output fpc_pkg::job_t pop_job
);
    import fpc_pkg::*;

    job_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;

    // back end never stalls: head leaves whenever present
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = q_mem_reg[rd_ptr_reg];
    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH)) || pop_valid;
    assign push       = push_valid && push_ready;

    always_comb
    begin
        unique case ({push, pop_valid})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- hw/rtl/fpc_back.sv -----
module fpc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    input  fpc_pkg::job_t                     pop_job,
    output logic                              done,
    output logic signed [fpc_pkg::OUT_W-1:0]  pressure_q8,
    output logic [fpc_pkg::SEG_W-1:0]         segment_used,
    output logic                              saturated,
    output logic                              zero_span
);
    import fpc_pkg::*;

    typedef struct packed {
        logic              neg;
        logic              zero;
        logic [SEG_W-1:0]  seg;
        logic [PRES_W-1:0] p0;
    } meta_t;

    localparam logic signed [VAL_W-1:0] OUT_MAX =
        {{(VAL_W-OUT_W){1'b0}}, 1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] OUT_MIN =
        {{(VAL_W-OUT_W){1'b1}}, 1'b1, {(OUT_W-1){1'b0}}};

    // stage A: product
    logic                     a_valid_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    logic signed [DIFF_W-1:0] a_span_reg;
    logic                     a_zero_reg;
    logic [SEG_W-1:0]         a_seg_reg;
    logic [PRES_W-1:0]        a_p0_reg;
    logic [PROD_W-1:0]        prod_mag;
    logic [DIFF_W-1:0]        span_mag;
    meta_t                    a_meta;

    // divider stages, one quotient bit each
    logic              dv_valid_reg [MAG_W+1];
    logic [MAG_W-1:0]  dv_num_reg   [MAG_W+1];
    logic [ADC_W-1:0]  dv_rem_reg   [MAG_W+1];
    logic [ADC_W-1:0]  dv_div_reg   [MAG_W+1];
    meta_t             dv_meta_reg  [MAG_W+1];
    logic [ADC_W:0]    dv_sh        [MAG_W];
    logic              dv_ge        [MAG_W];
    logic [ADC_W:0]    dv_sub       [MAG_W];
    logic [ADC_W-1:0]  dv_rem_next  [MAG_W];
    logic [MAG_W-1:0]  dv_num_next  [MAG_W];

    // final sum and output
    logic                    f_valid_reg;
    logic signed [VAL_W-1:0] f_val_reg;
    logic signed [VAL_W-1:0] f_val_next;
    logic                    f_zero_reg;
    logic [SEG_W-1:0]        f_seg_reg;
    logic signed [MAG_W:0]   q_ext;
    logic signed [MAG_W:0]   q_sgn;
    logic signed [VAL_W-1:0] p0_sh;
    meta_t                   last_meta;
    logic                    sat_hi;
    logic                    sat_lo;

    logic                    done_reg;
    logic signed [OUT_W-1:0] pressure_reg;
    logic signed [OUT_W-1:0] pressure_next;
    logic [SEG_W-1:0]        segment_reg;
    logic                    saturated_reg;
    logic                    zero_span_reg;

    always_ff @(posedge clk)
    begin
        a_prod_reg <= pop_job.dx * pop_job.dp;
        a_span_reg <= pop_job.span;
        a_zero_reg <= pop_job.zero;
        a_seg_reg  <= pop_job.seg;
        a_p0_reg   <= pop_job.p0;
    end

    assign prod_mag = a_prod_reg[PROD_W-1] ? PROD_W'(-a_prod_reg) : PROD_W'(a_prod_reg);
    assign span_mag = a_span_reg[DIFF_W-1] ? DIFF_W'(-a_span_reg) : DIFF_W'(a_span_reg);

    always_comb
    begin
        a_meta.neg  = a_prod_reg[PROD_W-1] ^ a_span_reg[DIFF_W-1];
        a_meta.zero = a_zero_reg;
        a_meta.seg  = a_seg_reg;
        a_meta.p0   = a_p0_reg;
    end

    always_comb
    begin
        for (int j = 0; j < MAG_W; j++)
        begin
            dv_sh[j]       = {dv_rem_reg[j], dv_num_reg[j][MAG_W-1]};
            dv_ge[j]       = (dv_sh[j] >= {1'b0, dv_div_reg[j]});
            dv_sub[j]      = dv_sh[j] - {1'b0, dv_div_reg[j]};
            dv_rem_next[j] = dv_ge[j] ? dv_sub[j][ADC_W-1:0] : dv_sh[j][ADC_W-1:0];
            dv_num_next[j] = {dv_num_reg[j][MAG_W-2:0], dv_ge[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        dv_num_reg[0]  <= MAG_W'(prod_mag[2*ADC_W-1:0]) << FRACTION_BITS;
        dv_rem_reg[0]  <= '0;
        dv_div_reg[0]  <= span_mag[ADC_W-1:0];
        dv_meta_reg[0] <= a_meta;
        for (int j = 0; j < MAG_W; j++)
        begin
            dv_num_reg[j+1]  <= dv_num_next[j];
            dv_rem_reg[j+1]  <= dv_rem_next[j];
            dv_div_reg[j+1]  <= dv_div_reg[j];
            dv_meta_reg[j+1] <= dv_meta_reg[j];
        end
    end

    assign last_meta = dv_meta_reg[MAG_W];
    assign q_ext     = $signed({1'b0, dv_num_reg[MAG_W]});
    assign p0_sh     = $signed(VAL_W'(last_meta.p0) << FRACTION_BITS);

    always_comb
    begin
        priority if (last_meta.neg && (dv_rem_reg[MAG_W] != '0))
            q_sgn = ~q_ext;
        else if (last_meta.neg)
            q_sgn = -q_ext;
        else
            q_sgn = q_ext;
        f_val_next = p0_sh + VAL_W'(q_sgn);
    end

    always_ff @(posedge clk)
    begin
        f_val_reg  <= f_val_next;
        f_zero_reg <= last_meta.zero;
        f_seg_reg  <= last_meta.seg;
    end

    assign sat_hi = (f_val_reg > OUT_MAX);
    assign sat_lo = (f_val_reg < OUT_MIN);

    always_comb
    begin
        priority if (f_zero_reg)
            pressure_next = '0;
        else if (sat_hi)
            pressure_next = OUT_MAX[OUT_W-1:0];
        else if (sat_lo)
            pressure_next = OUT_MIN[OUT_W-1:0];
        else
            pressure_next = f_val_reg[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        pressure_reg  <= pressure_next;
        segment_reg   <= f_seg_reg;
        saturated_reg <= !f_zero_reg && (sat_hi || sat_lo);
        zero_span_reg <= f_zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int j = 0; j <= MAG_W; j++)
                dv_valid_reg[j] <= 1'b0;
            f_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= pop_valid;
            dv_valid_reg[0] <= a_valid_reg;
            for (int j = 0; j < MAG_W; j++)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            f_valid_reg <= dv_valid_reg[MAG_W];
            done_reg    <= f_valid_reg;
        end
    end

    assign done         = done_reg;
    assign pressure_q8  = pressure_reg;
    assign segment_used = segment_reg;
    assign saturated    = saturated_reg;
    assign zero_span    = zero_span_reg;

endmodule

// ----- hw/rtl/fpc_checker.sv -----
module fpc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic signed [fpc_pkg::OUT_W-1:0]  pressure_q8,
    input logic [fpc_pkg::SEG_W-1:0]         segment_used,
    input logic                              saturated,
    input logic                              zero_span
);
    import fpc_pkg::*;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("accepted sample produced no result at pipeline latency");

    a_zero_span_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_span) |-> (pressure_q8 == '0) && !saturated)
        else $error("zero span result not cleared");

    a_segment_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (segment_used == SEG_1) || (segment_used == SEG_2)
                 || (segment_used == SEG_3))
        else $error("segment out of range");

    a_saturation_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (pressure_q8 == 32'sh7FFF_FFFF)
                                || (pressure_q8 == 32'sh8000_0000))
        else $error("saturated result not at a range limit");

endmodule

bind four_point_pressure_calibration fpc_checker u_fpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .pressure_q8  (pressure_q8),
    .segment_used (segment_used),
    .saturated    (saturated),
    .zero_span    (zero_span)
);

// ----- tb/four_point_pressure_calibration_test.sv -----
module four_point_pressure_calibration_test;
    import fpc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_SAMPLES = 476;

    typedef struct packed {
        logic signed [OUT_W-1:0] pressure;
        logic [SEG_W-1:0]        seg;
        logic                    sat;
        logic                    zero;
    } cal_result_t;

    typedef struct {
        logic                  is_cfg;
        cfg_reg_t              idx;
        logic [CFG_DATA_W-1:0] value;
    } stim_item_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [ADC_W-1:0]               adc_sample = '0;
    logic                           cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]           cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;
    logic                           done;
    logic signed [OUT_W-1:0]        pressure_q8;
    logic [SEG_W-1:0]               segment_used;
    logic                           saturated;
    logic                           zero_span;

    stim_item_t                     sample_plan[$];
    cal_result_t                    readings_due[$];
    logic [ADC_W-1:0]               cal_adc_copy [CAL_POINTS];
    logic [PRES_W-1:0]              cal_pres_copy [CAL_POINTS];
    int                             gap_left = 0;
    int                             burst_left = 0;
    int                             error_count = 0;
    int                             checked_count = 0;
    int                             table_count = 0;
    int                             cycle_count = 0;

    four_point_pressure_calibration uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .adc_sample   (adc_sample),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .pressure_q8  (pressure_q8),
        .segment_used (segment_used),
        .saturated    (saturated),
        .zero_span    (zero_span)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cal_result_t calibrate_sample(input logic [ADC_W-1:0] x);
        cal_result_t r;
        int k;
        longint xs, a0, a1, p0, p1, span, num, q, rem, val;
        k = 3;
        for (int i = CAL_POINTS - 1; i >= 1; i--)
        begin
            if (cal_adc_copy[i] > x)
                k = i;
        end
        xs = longint'(x);
        a0 = longint'(cal_adc_copy[k-1]);
        a1 = longint'(cal_adc_copy[k]);
        p0 = longint'(cal_pres_copy[k-1]);
        p1 = longint'(cal_pres_copy[k]);
        span = a1 - a0;
        r.seg = SEG_W'(k);
        r.sat = 1'b0;
        r.zero = 1'b0;
        if (span == 0)
        begin
            r.zero = 1'b1;
            val = 0;
        end
        else
        begin
            num = (xs - a0) * (p1 - p0) * (longint'(1) <<< FRACTION_BITS);
            q = num / span;
            rem = num % span;
            if (rem != 0 && ((rem < 0) != (span < 0)))
                q = q - 1;
            val = (p0 <<< FRACTION_BITS) + q;
            if (val > longint'(32'sh7FFFFFFF))
            begin
                val = longint'(32'sh7FFFFFFF);
                r.sat = 1'b1;
            end
            else if (val < -longint'(64'sh80000000))
            begin
                val = -longint'(64'sh80000000);
                r.sat = 1'b1;
            end
        end
        r.pressure = OUT_W'(val);
        return r;
    endfunction

    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic push_sample(input logic [ADC_W-1:0] x);
        stim_item_t it;
        it.is_cfg = 1'b0;
        it.idx = REG_CAL_ADC_0;
        it.value = x;
        sample_plan.push_back(it);
    endtask

    task automatic push_table(input logic [ADC_W-1:0] a [CAL_POINTS],
                              input logic [PRES_W-1:0] p [CAL_POINTS]);
        stim_item_t it;
        it.is_cfg = 1'b1;
        for (int i = 0; i < CAL_POINTS; i++)
        begin
            it.idx = cfg_reg_t'(REG_CAL_ADC_0 + i);
            it.value = a[i];
            sample_plan.push_back(it);
            it.idx = cfg_reg_t'(REG_CAL_PRES_0 + i);
            it.value = p[i];
            sample_plan.push_back(it);
        end
        table_count++;
    endtask

    task automatic add_random_phase(input int count);
        logic [ADC_W-1:0]  a [CAL_POINTS];
        logic [PRES_W-1:0] p [CAL_POINTS];
        logic [ADC_W-1:0]  pts[$];
        int kind, base, v, r, j;
        kind = $urandom_range(0, 5);
        pts.delete();
        for (int i = 0; i < CAL_POINTS; i++)
        begin
            pts.push_back(ADC_W'($urandom_range(0, 65535)));
            p[i] = PRES_W'($urandom_range(0, 65535));
        end
        if (kind != 3)
            pts.sort();
        for (int i = 0; i < CAL_POINTS; i++)
            a[i] = pts[i];
        case (kind)
            2:
            begin
                // narrow spans drive the quotient far out of range
                base = $urandom_range(0, 65000);
                for (int i = 0; i < CAL_POINTS; i++)
                begin
                    base = base + $urandom_range(0, 3);
                    a[i] = ADC_W'(base);
                    p[i] = $urandom_range(0, 1) ? 16'hFFFF : PRES_W'($urandom_range(0, 65535));
                end
            end
            4:
            begin
                for (int i = 0; i < CAL_POINTS; i++)
                begin
                    r = $urandom_range(0, 2);
                    a[i] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : a[i];
                    p[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
            end
            5:
            begin
                j = $urandom_range(0, 2);
                a[j+1] = a[j];
            end
            default:
            begin
            end
        endcase
        push_table(a, p);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
            begin
                v = int'(a[$urandom_range(0, CAL_POINTS - 1)]) + int'($urandom_range(0, 4)) - 2;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                push_sample(ADC_W'(v));
            end
            else if (r == 3)
                push_sample($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            else
                push_sample(ADC_W'($urandom_range(0, 65535)));
        end
    endtask

    // driver: samples and register writes in plan order; writes only when drained
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            adc_sample <= '0;
            cfg_write <= 1'b0;
            cfg_index <= REG_CAL_ADC_0;
            cfg_data <= '0;
            gap_left = 0;
            cal_adc_copy = CAL_ADC_RST;
            cal_pres_copy = CAL_PRES_RST;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_reg_t'(cfg_index) <= REG_CAL_ADC_3)
                    cal_adc_copy[cfg_index[1:0]] = cfg_data;
                else
                    cal_pres_copy[cfg_index[1:0]] = cfg_data;
            end
            if (start && !busy)
                readings_due.push_back(calibrate_sample(adc_sample));
            if (start && busy)
                cfg_write <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
                cfg_write <= 1'b0;
            end
            else if (sample_plan.size() == 0)
            begin
                start <= 1'b0;
                cfg_write <= 1'b0;
            end
            else if (sample_plan[0].is_cfg)
            begin
                start <= 1'b0;
                if (readings_due.size() == 0 && !start)
                begin
                    cfg_write <= 1'b1;
                    cfg_index <= sample_plan[0].idx;
                    cfg_data <= sample_plan[0].value;
                    void'(sample_plan.pop_front());
                end
                else
                    cfg_write <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                adc_sample <= sample_plan[0].value;
                cfg_write <= 1'b0;
                void'(sample_plan.pop_front());
                gap_left = next_gap();
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        cal_result_t want;
        if (rst_n && done)
        begin
            if (readings_due.size() == 0)
            begin
                $error("result with none pending: pressure_q8 %0d", pressure_q8);
                error_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                checked_count++;
                if (pressure_q8 !== want.pressure)
                begin
                    $error("pressure_q8: expected %0d, got %0d", want.pressure, pressure_q8);
                    error_count++;
                end
                if (segment_used !== want.seg)
                begin
                    $error("segment_used: expected %0d, got %0d", want.seg, segment_used);
                    error_count++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated: expected %0b, got %0b", want.sat, saturated);
                    error_count++;
                end
                if (zero_span !== want.zero)
                begin
                    $error("zero_span: expected %0b, got %0b", want.zero, zero_span);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : main
        int left, n;
        // default table: breakpoints, neighbors and both ends
        push_sample(16'd0);
        push_sample(16'd1);
        push_sample(16'd21844);
        push_sample(16'd21845);
        push_sample(16'd21846);
        push_sample(16'd43689);
        push_sample(16'd43690);
        push_sample(16'd65534);
        push_sample(16'd65535);
        // unit spans with full-scale swing: positive overflow
        push_table('{16'd0, 16'd1, 16'd2, 16'd3}, '{16'd0, 16'd65535, 16'd0, 16'd65535});
        push_sample(16'd65535);
        push_sample(16'd3);
        push_sample(16'd0);
        // far below the first point: negative overflow; top segment of zero width
        push_table('{16'd65533, 16'd65534, 16'd65535, 16'd65535},
                   '{16'd0, 16'd65535, 16'd65535, 16'd65535});
        push_sample(16'd0);
        push_sample(16'd65534);
        push_sample(16'd65535);
        // non-monotonic breakpoints, negative spans
        push_table('{16'd60000, 16'd10000, 16'd50000, 16'd5000},
                   '{16'd65535, 16'd0, 16'd12345, 16'd40000});
        push_sample(16'd0);
        push_sample(16'd7000);
        push_sample(16'd30000);
        push_sample(16'd55000);
        push_sample(16'd65535);
        push_table('{16'd0, 16'd0, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0, 16'd0});
        push_sample(16'd0);
        push_sample(16'd65535);
        push_table('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                   '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        push_sample(16'd0);
        push_sample(16'd65535);

        left = RANDOM_SAMPLES;
        while (left > 0)
        begin
            n = $urandom_range(25, 60);
            if (n > left)
                n = left;
            add_random_phase(n);
            left = left - n;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (sample_plan.size() != 0 || start || cfg_write || readings_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        $display("Checked %0d calibrated readings over %0d calibration tables",
                 checked_count, table_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/fpc_pkg.sv
hw/rtl/fpc_front.sv
hw/rtl/fpc_queue.sv
hw/rtl/fpc_back.sv
hw/rtl/four_point_pressure_calibration.sv
hw/rtl/fpc_checker.sv
tb/four_point_pressure_calibration_test.sv
